/* hdl/assert_macros.svh */
// Assertion helpers shared by checker modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ggr3_pkg.sv */
`default_nettype none

package ggr3_pkg;

    // Field and register widths
    localparam int PIX_W  = 8;
    localparam int HSUM_W = 10;
    localparam int SUM_W  = 12;
    localparam int FW_W   = 13;
    localparam int FH_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Defaults
    localparam int DEF_MAX_WIDTH = 4096;
    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = FW_W'(640);
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = FH_W'(480);
    localparam logic            RST_ROUND_MODE   = 1'b1;

    // Divide by 16 with optional rounding
    localparam int ROUND_ADD = 8;
    localparam int DIV_SHIFT = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_ROUND_MODE   = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

/* hdl/gray_gaussian_reduce_3x3.sv */
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------
// in       | input     | in_valid / in_ready | pixel[7:0]
// out      | output    | out_valid/out_ready | out_pixel[7:0], end_of_row, end_of_frame
// cfg      | input     | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[15:0]
//
// One pixel request per clock is sustained while the output drains; the line
// stores are registered read-first RAMs, read and written in the accept cycle,
// so no entry is ever in flight. A result passes the read stage, then the output register.
// Reset clears position, pixel window and pipeline valids; line stores need no
// clearing pass since every read hits an entry written earlier in the frame.
// A stalled output holds its request; in_ready drops only when both the
// output register and the read stage hold a result.
`default_nettype none

module gray_gaussian_reduce_3x3
    import ggr3_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PIX_W-1:0]      pixel,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [PIX_W-1:0]      out_pixel,
    output logic                       end_of_row,
    output logic                       end_of_frame,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Column counter width, comparison width, line store geometry
    localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
    localparam int SD = (MAX_WIDTH + 1) / 2;
    localparam int AW = (SD > 1) ? $clog2(SD) : 1;

    // Configuration registers
    logic [FW_W-1:0]   frame_width_reg;
    logic [FH_W-1:0]   frame_height_reg;
    logic              round_mode_reg;

    // Position and the two previous pixels of the stream
    logic [CW-1:0]     col_reg,  col_next;
    logic [FH_W-1:0]   row_reg,  row_next;
    logic [PIX_W-1:0]  pw0_reg, pw1_reg;

    // Read stage: lines up with the registered line store data
    logic              s1_valid_reg, s1_valid_next;
    logic [HSUM_W-1:0] s1_hs_reg;
    logic              s1_odd_row_reg, s1_first_row_reg, s1_eor_reg, s1_eof_reg;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              out_eor_reg, out_eof_reg;

    logic              in_fire, cfg_fire, dim_write, s1_move;
    logic [WW-1:0]     fw_ext, eff_w, w_m1;
    logic [FH_W-1:0]   h_m1;
    logic              last_col, last_row, odd_row, first_row, have_h, emit;
    logic [PIX_W-1:0]  first_tap;
    logic [HSUM_W-1:0] hs;
    logic [AW-1:0]     store_addr;
    logic              older_we, newer_we;
    logic [HSUM_W-1:0] older_rd, newer_rd, older_term, mid_term;
    logic [SUM_W-1:0]  vsum;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign dim_write = cfg_fire && ((cfg_index == REG_FRAME_WIDTH) ||
                                    (cfg_index == REG_FRAME_HEIGHT));

    // Read stage advances whenever the output register is free or drains
    assign s1_move  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Effective frame size: width clamped to 2..MAX_WIDTH, height zero as one
    always_comb
    begin
        fw_ext = WW'(frame_width_reg);
        if (fw_ext < WW'(2))
        begin
            eff_w = WW'(2);
        end
        else if (fw_ext > WW'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = fw_ext;
        end
        w_m1 = eff_w - WW'(1);
        h_m1 = (frame_height_reg == '0) ? '0 : frame_height_reg - FH_W'(1);
    end

    assign last_col  = (WW'(col_reg) == w_m1);
    assign last_row  = (row_reg == h_m1);
    assign odd_row   = row_reg[0];
    assign first_row = (row_reg == '0);
    assign have_h    = col_reg[0] || last_col;
    assign emit      = have_h && (odd_row || last_row);

    // Horizontal 1-2-1 sum; left edge replicates column 0, right edge the last pixel
    assign first_tap = (col_reg == CW'(1)) ? pw0_reg : pw1_reg;
    always_comb
    begin
        if (col_reg[0])
        begin
            hs = HSUM_W'(first_tap) + {1'b0, pw0_reg, 1'b0} + HSUM_W'(pixel);
        end
        else
        begin
            hs = HSUM_W'(pw0_reg) + {1'b0, pixel, 1'b0} + HSUM_W'(pixel);
        end
    end

    assign store_addr = AW'(col_reg >> 1);
    // Odd rows shift the newest sum into the older store; even rows refresh
    // the newer store, and row 0 also seeds the older one (top edge replicate)
    assign older_we = in_fire && have_h && (odd_row || first_row);
    assign newer_we = in_fire && have_h && !odd_row;

    ggr3_ram #(
        .WIDTH (HSUM_W),
        .DEPTH (SD),
        .AW    (AW)
    ) u_older_store (
        .clk     (clk),
        .wr_en   (older_we),
        .wr_addr (store_addr),
        .wr_data (hs),
        .rd_en   (in_fire),
        .rd_addr (store_addr),
        .rd_data (older_rd)
    );

    ggr3_ram #(
        .WIDTH (HSUM_W),
        .DEPTH (SD),
        .AW    (AW)
    ) u_newer_store (
        .clk     (clk),
        .wr_en   (newer_we),
        .wr_addr (store_addr),
        .wr_data (hs),
        .rd_en   (in_fire),
        .rd_addr (store_addr),
        .rd_data (newer_rd)
    );

    // Vertical 1-2-1 sum on the read stage; bottom edge replicates the last row
    always_comb
    begin
        if (s1_odd_row_reg)
        begin
            older_term = older_rd;
            mid_term   = newer_rd;
        end
        else
        begin
            older_term = s1_first_row_reg ? s1_hs_reg : older_rd;
            mid_term   = s1_hs_reg;
        end
        vsum = SUM_W'(older_term) + {1'b0, mid_term, 1'b0} + SUM_W'(s1_hs_reg)
             + (round_mode_reg ? SUM_W'(ROUND_ADD) : SUM_W'(0));
    end

    // Raster position; a dimension write restarts the frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (dim_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_fire)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + FH_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = emit;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            round_mode_reg   <= RST_ROUND_MODE;
            col_reg          <= '0;
            row_reg          <= '0;
            pw0_reg          <= '0;
            pw1_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                    REG_ROUND_MODE:   round_mode_reg   <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (in_fire)
            begin
                pw1_reg <= pw0_reg;
                pw0_reg <= pixel;
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: hold while stalled, advance with the valid bits
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_hs_reg        <= hs;
            s1_odd_row_reg   <= odd_row;
            s1_first_row_reg <= first_row;
            s1_eor_reg       <= last_col;
            s1_eof_reg       <= last_col && last_row;
        end
        if (s1_move)
        begin
            out_pixel_reg <= PIX_W'(vsum >> DIV_SHIFT);
            out_eor_reg   <= s1_eor_reg;
            out_eof_reg   <= s1_eof_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pixel    = out_pixel_reg;
    assign end_of_row   = out_eor_reg;
    assign end_of_frame = out_eof_reg;

endmodule

`default_nettype wire

/* hdl/ggr3_ram.sv */
`default_nettype none

module ggr3_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read and write to the same entry return the old value
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/ggr3_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module ggr3_checker
    import ggr3_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [PIX_W-1:0]      out_pixel,
    input wire logic                  end_of_row,
    input wire logic                  end_of_frame
);

    logic             in_take;
    logic             out_wait;
    logic [PIX_W+1:0] out_bus;

    assign in_take  = in_valid && in_ready;
    assign out_wait = out_valid && !out_ready;
    assign out_bus  = {out_pixel, end_of_row, end_of_frame};

    // A stalled result holds its request and payload
    `ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_bus), "stalled result changed")

    // Frame end always closes a row
    `ASSERT_NOW(a_eof_eor, out_valid && end_of_frame, end_of_row, "frame end without row end")

    // An empty output register never blocks input
    `ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input blocked with empty output")

    // A fresh result follows an earlier pixel request
    `ASSERT_NOW(a_out_cause, $rose(out_valid), $past(in_take, 2), "result without pixel")

endmodule

bind gray_gaussian_reduce_3x3 ggr3_checker u_ggr3_checker (.*);

`default_nettype wire

/* tb/sv/gray_gaussian_reduce_3x3_tb.sv */
`default_nettype none

module gray_gaussian_reduce_3x3_tb
    import ggr3_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Frame geometry and run control
    localparam int          TB_MAX_WIDTH   = DEF_MAX_WIDTH;
    localparam int          STORE_DEPTH    = (TB_MAX_WIDTH + 1) / 2;
    localparam int unsigned POR_WIDTH      = 640;
    localparam int unsigned POR_HEIGHT     = 480;
    localparam bit          POR_ROUND      = 1'b1;
    localparam int          RANDOM_ITEMS   = 1120;
    localparam int          WIDE_ITEMS     = 256;
    localparam int          HOLD_OFF_CYCLES = 250;
    // Margin for the pipeline to drain after the last owed result.
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          TAIL_CYCLES    = 16;
    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          MAX_REPORTS    = 40;

    // One decimated output request as the block presents it
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             row_end;
        logic             frame_end;
    } reduced_t;

    // Tracks the block: a bit-accurate copy of the 1-2-1 x 1-2-1 reduce with
    // its own line stores, plus the queue of decimated pixels still owed.
    class reduce_scoreboard;
        logic [FW_W-1:0]   frame_w;
        logic [FH_W-1:0]   frame_h;
        logic              round_on;
        int unsigned       col_pos;
        int unsigned       row_pos;
        logic [PIX_W-1:0]  left1_pix;
        logic [PIX_W-1:0]  left2_pix;
        logic [HSUM_W-1:0] hsum_older [STORE_DEPTH];
        logic [HSUM_W-1:0] hsum_newer [STORE_DEPTH];
        reduced_t          reduced_q [$];
        int                errors;

        function new();
            frame_w   = FW_W'(POR_WIDTH);
            frame_h   = FH_W'(POR_HEIGHT);
            round_on  = POR_ROUND;
            col_pos   = 0;
            row_pos   = 0;
            left1_pix = '0;
            left2_pix = '0;
            foreach (hsum_older[i])
            begin
                hsum_older[i] = '0;
                hsum_newer[i] = '0;
            end
            errors = 0;
        endfunction

        function int unsigned tap121(int unsigned a, int unsigned b, int unsigned c);
            return a + 2 * b + c;
        endfunction

        function int unsigned pending();
            return reduced_q.size();
        endfunction

        // Dimension writes restart the frame; round mode applies to the next result.
        function void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:
                begin
                    frame_w = data[FW_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
                REG_FRAME_HEIGHT:
                begin
                    frame_h = data[FH_W-1:0];
                    col_pos = 0;
                    row_pos = 0;
                end
                REG_ROUND_MODE:
                    round_on = data[0];
                default:
                    ;
            endcase
        endfunction

        function void note_pixel(logic [PIX_W-1:0] p);
            int unsigned w;
            int unsigned h;
            int unsigned hs;
            int unsigned k;
            int unsigned v;
            bit          last_col;
            bit          last_row;
            bit          have_h;
            bit          emit;
            reduced_t    r;

            w = 32'(frame_w);
            if (w < 2) w = 2;
            if (w > TB_MAX_WIDTH) w = TB_MAX_WIDTH;
            h = (frame_h == '0) ? 1 : 32'(frame_h);
            last_col = (col_pos == w - 1);
            last_row = (row_pos == h - 1);
            have_h = 1'b1;
            emit = 1'b0;
            hs = 0;
            k = 0;
            v = 0;

            // Horizontal sum of the even column closes on the odd pixel after it,
            // or on the pixel itself at an even last column (replicate right edge).
            if ((col_pos % 2) == 1)
            begin
                k = (col_pos - 1) / 2;
                hs = tap121(32'((col_pos == 1) ? left1_pix : left2_pix),
                            32'(left1_pix), 32'(p));
            end
            else if (last_col)
            begin
                k = col_pos / 2;
                hs = tap121(32'(left1_pix), 32'(p), 32'(p));
            end
            else
            begin
                have_h = 1'b0;
            end

            if (have_h)
            begin
                if ((row_pos % 2) == 1)
                begin
                    v = tap121(32'(hsum_older[k]), 32'(hsum_newer[k]), hs);
                    hsum_older[k] = HSUM_W'(hs);
                    emit = 1'b1;
                end
                else
                begin
                    // Row zero stands in for the missing row above it
                    if (row_pos == 0) hsum_older[k] = HSUM_W'(hs);
                    hsum_newer[k] = HSUM_W'(hs);
                    if (last_row)
                    begin
                        v = tap121(32'(hsum_older[k]), hs, hs);
                        emit = 1'b1;
                    end
                end
            end

            if (emit)
            begin
                if (round_on) v = v + ROUND_ADD;
                v = v >> DIV_SHIFT;
                r.value     = PIX_W'(v);
                r.row_end   = last_col;
                r.frame_end = last_col && last_row;
                reduced_q.push_back(r);
            end

            left2_pix = left1_pix;
            left1_pix = p;
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) row_pos = 0;
            end
        endfunction

        function void check_result(reduced_t got);
            reduced_t want;
            if (reduced_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result: actual pixel %0d eor %b eof %b",
                             $time, got.value, got.row_end, got.frame_end);
            end
            else
            begin
                want = reduced_q.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"%0t: mismatch: expected pixel %0d eor %b eof %b,",
                                  " actual pixel %0d eor %b eof %b"},
                                 $time, want.value, want.row_end, want.frame_end,
                                 got.value, got.row_end, got.frame_end);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      out_pixel;
    logic                  end_of_row;
    logic                  end_of_frame;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit                    hold_off_req = 1'b0;
    int                    cycle_count = 0;
    logic [PIX_W-1:0]      directed_q [$];
    reduce_scoreboard      board = new();

    gray_gaussian_reduce_3x3 dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel        (pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_pixel    (out_pixel),
        .end_of_row   (end_of_row),
        .end_of_frame (end_of_frame),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still owed",
                     $time, cycle_count, board.pending());
            $display("gray_gaussian_reduce_3x3 test failed");
            $finish;
        end
    end

    // Observe every handshake at the edge where it completes. Register writes
    // and pixel requests never share an edge, so the order here is immaterial.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.apply_reg(cfg_reg_t'(cfg_index), cfg_data);
            if (in_valid && in_ready)
                board.note_pixel(pixel);
            if (out_valid && out_ready)
                board.check_result(reduced_t'{value: out_pixel, row_end: end_of_row,
                                              frame_end: end_of_frame});
        end
    end

    // Receiver: switch between stall patterns at random intervals, and
    // hold off completely for a long stretch when the sender asks for it.
    initial
    begin : receiver
        int pattern;
        int left;
        pattern = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    pattern = $urandom_range(0, 3);
                    left = $urandom_range(20, 300);
                end
                left--;
                case (pattern)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((left % 4) == 0);
                endcase
            end
        end
    end

    // Write one register; drop the request afterwards so that a
    // following write never lowers and raises valid in the same step.
    task automatic program_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer count pixels, from the directed list or random. Hold each request
    // until accepted; between bursts, unless back to back, drop valid for a random gap. The last
    // request always ends with valid low.
    task automatic stream_pixels(input int count, input bit from_list, input bit back_to_back);
        int               burst_left;
        int               i;
        logic [PIX_W-1:0] value;
        burst_left = $urandom_range(1, 24);
        for (i = 0; i < count; i++)
        begin
            if (from_list)
                value = directed_q.pop_front();
            else if ($urandom_range(0, 7) == 0)
                value = $urandom_range(0, 1) ? '1 : '0;
            else
                value = PIX_W'($urandom_range(0, 255));
            in_valid <= 1'b1;
            pixel    <= value;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            burst_left--;
            if (i == count - 1)
            begin
                in_valid <= 1'b0;
            end
            else if (!back_to_back && burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 24);
            end
        end
    endtask

    // Wait until every owed result has arrived, then let the pipeline settle
    // so that pixels that produce nothing are also through.
    task automatic wait_idle();
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int random_sent;
        int choice;
        int fw;
        int fh;
        int count;

        random_sent = 0;
        fw = 2;
        fh = 1;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Power-on geometry: a few pixels of row zero, no results due.
        directed_q = '{8'd0, 8'd255, 8'd255, 8'd0};
        stream_pixels(4, 1'b1, 1'b0);
        wait_idle();

        // 3x3 frame: odd width and height exercise right and bottom edge
        // replication; the width write also restarts the half-done frame.
        program_reg(REG_FRAME_WIDTH, 16'd3);
        program_reg(REG_FRAME_HEIGHT, 16'd3);
        program_reg(REG_ROUND_MODE, 16'd1);
        directed_q = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        stream_pixels(9, 1'b1, 1'b0);
        wait_idle();

        // Truncating divide on a 2x2 frame.
        program_reg(REG_ROUND_MODE, 16'd0);
        program_reg(REG_FRAME_WIDTH, 16'd2);
        program_reg(REG_FRAME_HEIGHT, 16'd2);
        directed_q = '{8'd7, 8'd9, 8'd0, 8'd255};
        stream_pixels(4, 1'b1, 1'b0);
        wait_idle();

        // Zero width and zero height clamp to 2x1; the unused index is ignored.
        program_reg(REG_FRAME_WIDTH, 16'd0);
        program_reg(REG_FRAME_HEIGHT, 16'd0);
        program_reg(REG_UNUSED, 16'hFFFF);
        directed_q = '{8'd255, 8'd255};
        stream_pixels(2, 1'b1, 1'b0);
        wait_idle();

        // Width one also clamps to two; round mode back on with all data bits set.
        program_reg(REG_FRAME_WIDTH, 16'd1);
        program_reg(REG_FRAME_HEIGHT, 16'd1);
        program_reg(REG_ROUND_MODE, 16'hFFFF);
        directed_q = '{8'd128, 8'd127, 8'd255, 8'd0};
        stream_pixels(4, 1'b1, 1'b0);
        wait_idle();

        // Backpressure: hold the receiver off while pixels keep coming so the
        // block fills up and drops in_ready; then pause until all results land.
        program_reg(REG_FRAME_WIDTH, 16'd2);
        program_reg(REG_FRAME_HEIGHT, 16'd1);
        hold_off_req = 1'b1;
        stream_pixels(80, 1'b0, 1'b1);
        wait_idle();

        // Widest frame: an over-range width with stray upper data bits acts as
        // the maximum; a single row, and only its first part, keeps it short.
        program_reg(REG_FRAME_WIDTH, 16'hFFFF);
        program_reg(REG_FRAME_HEIGHT, 16'd1);
        program_reg(REG_ROUND_MODE, 16'($urandom));
        stream_pixels(WIDE_ITEMS, 1'b0, 1'b0);
        wait_idle();

        // Tallest frame: only the top rows are ever reached.
        program_reg(REG_FRAME_WIDTH, 16'd2);
        program_reg(REG_FRAME_HEIGHT, 16'hFFFF);
        stream_pixels(64, 1'b0, 1'b0);
        wait_idle();

        // Random phases: mostly whole frames of small size, sometimes a cut-off
        // frame, sometimes a round mode change in the middle of a frame.
        while (random_sent < RANDOM_ITEMS)
        begin
            choice = $urandom_range(0, 9);
            if (choice < 6 || random_sent == 0)
            begin
                fw = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 64)
                                                 : $urandom_range(2, 12);
                fh = $urandom_range(1, 6);
                program_reg(REG_FRAME_WIDTH, {3'($urandom_range(0, 7)), FW_W'(fw)});
                program_reg(REG_FRAME_HEIGHT, FH_W'(fh));
            end
            if (choice >= 4 && choice < 8)
                program_reg(REG_ROUND_MODE, 16'($urandom));
            if (choice == 9)
                program_reg(REG_UNUSED, 16'($urandom));
            if ($urandom_range(0, 4) != 0)
                count = fw * fh * $urandom_range(1, 3);
            else
                count = $urandom_range(1, 2 * fw * fh);
            if (count > RANDOM_ITEMS - random_sent)
                count = RANDOM_ITEMS - random_sent;
            stream_pixels(count, 1'b0, 1'b0);
            random_sent += count;
            wait_idle();
        end

        // Catch anything spurious that trails the last expected result.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("gray_gaussian_reduce_3x3 test passed");
        else
            $display("gray_gaussian_reduce_3x3 test failed");
        $finish;
    end

endmodule

`default_nettype wire

/* gray_gaussian_reduce_3x3.f */
+incdir+hdl
hdl/ggr3_pkg.sv
hdl/ggr3_ram.sv
hdl/gray_gaussian_reduce_3x3.sv
hdl/ggr3_checker.sv
tb/sv/gray_gaussian_reduce_3x3_tb.sv
